// ----- src/jbpm_pkg.sv -----
// Shared constants, types and helper functions for the job block pool manager.
package jbpm_pkg;

   localparam int POOL_SIZE     = 16;
   localparam int PRIORITY_BITS = 8;

   localparam int IDX_W  = $clog2(POOL_SIZE);
   localparam int LINK_W = $clog2(POOL_SIZE + 1);

   // Field widths of the stream beats.
   localparam int OP_W           = 2;
   localparam int BLOCK_INDEX_W  = 4;
   localparam int PRIORITY_REQ_W = 8;
   localparam int REQ_TUSER_W    = OP_W;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 8;

   // The link value one past the last block marks the end of a list.
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

   localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
   localparam logic [OP_W-1:0] OP_PUSH     = 2'd2;
   localparam logic [OP_W-1:0] OP_POP      = 2'd3;

   typedef logic [LINK_W-1:0]        link_type;
   typedef logic [PRIORITY_BITS-1:0] prio_type;

   typedef struct packed {
      logic capture;  // latch the request beat and read both stores
      logic execute;  // apply the operation and load the result register
      logic append;   // chain the released block behind the old free tail
   } jbpm_cmd_type;

   typedef struct packed {
      logic out_busy;       // result register full and not being drained
      logic append_needed;  // the held release needs a second link write
   } jbpm_status_type;

   function automatic link_type reset_link(input logic [IDX_W-1:0] idx);
      return LINK_W'(idx) + LINK_W'(1);
   endfunction

   function automatic logic is_block(input link_type link);
      return link < NULL_LINK;
   endfunction

endpackage

// ----- src/jbpm_ctrl.sv -----
// Sequencer that steps each request beat through capture, execute and, for a release that needs it, append.
module jbpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  jbpm_pkg::jbpm_status_type status,
   output jbpm_pkg::jbpm_cmd_type    cmd
);
   import jbpm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_APPEND = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Wait here while the previous result is still unclaimed.
            if (!status.out_busy) begin
               cmd.execute = 1'b1;
               state_in    = status.append_needed ? ST_APPEND : ST_IDLE;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/jbpm_dpath.sv -----
// List heads, link and priority stores, operation logic and result register.
module jbpm_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  jbpm_pkg::jbpm_cmd_type                 cmd,
   output jbpm_pkg::jbpm_status_type              status,
   input  logic [jbpm_pkg::OP_W-1:0]              req_operation,
   input  logic [jbpm_pkg::BLOCK_INDEX_W-1:0]     req_block_index,
   input  logic                                   req_block_present,
   input  logic [jbpm_pkg::PRIORITY_REQ_W-1:0]    req_priority_req,
   input  logic                                   rsp_tready,
   output logic                                   rsp_valid,
   output logic                                   rsp_result_present,
   output logic [jbpm_pkg::BLOCK_INDEX_W-1:0]     rsp_result_index,
   output logic                                   rsp_free_empty,
   output logic                                   rsp_run_empty
);
   import jbpm_pkg::*;

   // Held request beat.
   logic [OP_W-1:0] op_ff;
   link_type        blk_ff;
   logic            present_ff;
   prio_type        prio_ff;

   // List heads.
   link_type free_head_ff, free_head_in;
   link_type free_tail_ff, free_tail_in;
   link_type run_head_ff,  run_head_in;

   // Shared next-link store; an entry never written reads as its reset link.
   link_type               link_mem_ff [POOL_SIZE];
   logic [POOL_SIZE-1:0]   link_valid_ff;
   link_type               link_rd_ff;
   logic                   link_rd_valid_ff;
   logic [IDX_W-1:0]       link_rd_addr_ff;
   link_type               link_raddr;
   link_type               link_val;
   logic                   link_we;
   logic [IDX_W-1:0]       link_waddr;
   link_type               link_wdata;

   prio_type prio_mem_ff [POOL_SIZE];
   prio_type prio_rd_ff;
   logic     prio_we;

   link_type res;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_present_ff;
   logic [BLOCK_INDEX_W-1:0] rsp_index_ff;
   logic                     rsp_free_empty_ff;
   logic                     rsp_run_empty_ff;

   assign link_raddr = (req_operation == OP_ALLOCATE) ? free_head_ff : run_head_ff;
   assign link_val   = link_rd_valid_ff ? link_rd_ff : reset_link(link_rd_addr_ff);

   assign status.append_needed = (op_ff == OP_RELEASE) && present_ff &&
                                 is_block(free_head_ff) && is_block(free_tail_ff);
   assign status.out_busy      = rsp_valid_ff && !rsp_tready;

   always_comb begin
      free_head_in = free_head_ff;
      free_tail_in = free_tail_ff;
      run_head_in  = run_head_ff;
      link_we      = 1'b0;
      link_waddr   = '0;
      link_wdata   = NULL_LINK;
      prio_we      = 1'b0;
      res          = NULL_LINK;
      if (cmd.execute) begin
         unique case (op_ff)
            OP_ALLOCATE: begin
               if (is_block(free_head_ff)) begin
                  res        = free_head_ff;
                  link_we    = 1'b1;
                  link_waddr = free_head_ff[IDX_W-1:0];
                  if (is_block(link_val)) begin
                     free_head_in = link_val;
                  end else begin
                     free_head_in = NULL_LINK;
                     free_tail_in = NULL_LINK;
                  end
               end
            end
            OP_RELEASE: begin
               if (present_ff) begin
                  res        = blk_ff;
                  link_we    = 1'b1;
                  link_waddr = blk_ff[IDX_W-1:0];
                  // A broken free list (either end null) restarts from this block.
                  if (!status.append_needed) begin
                     free_head_in = blk_ff;
                     free_tail_in = blk_ff;
                  end
               end
            end
            OP_PUSH: begin
               if (present_ff && (!is_block(run_head_ff) || prio_rd_ff > prio_ff)) begin
                  res         = blk_ff;
                  link_we     = 1'b1;
                  link_waddr  = blk_ff[IDX_W-1:0];
                  link_wdata  = run_head_ff;
                  prio_we     = 1'b1;
                  run_head_in = blk_ff;
               end
            end
            OP_POP: begin
               if (is_block(run_head_ff)) begin
                  res         = run_head_ff;
                  run_head_in = is_block(link_val) ? link_val : NULL_LINK;
               end
            end
            default: begin
               res = NULL_LINK;
            end
         endcase
      end else if (cmd.append) begin
         link_we      = 1'b1;
         link_waddr   = free_tail_ff[IDX_W-1:0];
         link_wdata   = blk_ff;
         free_tail_in = blk_ff;
      end
   end

   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_tail_ff  <= LINK_W'(POOL_SIZE - 1);
         run_head_ff   <= NULL_LINK;
         link_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         free_tail_ff <= free_tail_in;
         run_head_ff  <= run_head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (link_we) begin
            link_valid_ff[link_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem_ff[link_waddr] <= link_wdata;
      end
      if (prio_we) begin
         prio_mem_ff[blk_ff[IDX_W-1:0]] <= prio_ff;
      end
      if (cmd.capture) begin
         link_rd_ff       <= link_mem_ff[link_raddr[IDX_W-1:0]];
         link_rd_valid_ff <= link_valid_ff[link_raddr[IDX_W-1:0]];
         link_rd_addr_ff  <= link_raddr[IDX_W-1:0];
         prio_rd_ff       <= prio_mem_ff[run_head_ff[IDX_W-1:0]];
         op_ff            <= req_operation;
         blk_ff           <= LINK_W'(req_block_index);
         present_ff       <= req_block_present && (int'(req_block_index) < POOL_SIZE);
         prio_ff          <= PRIORITY_BITS'(req_priority_req);
      end
      if (cmd.execute) begin
         rsp_present_ff    <= is_block(res);
         rsp_index_ff      <= is_block(res) ? BLOCK_INDEX_W'(res) : '0;
         rsp_free_empty_ff <= !is_block(free_head_in);
         rsp_run_empty_ff  <= !is_block(run_head_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_present = rsp_present_ff;
   assign rsp_result_index   = rsp_index_ff;
   assign rsp_free_empty     = rsp_free_empty_ff;
   assign rsp_run_empty      = rsp_run_empty_ff;

endmodule

// ----- src/job_block_pool_manager.sv -----
// Top level of the job block pool manager: stream ports, sequencer and datapath.
//
// Manages a pool of 16 job blocks kept on a FIFO free list (allocate from
// the head, release to the tail) and a priority-ordered run stack (push
// only if strictly more urgent than the head, pop from the head). Each
// request beat gives exactly one result beat. A request is captured, reading
// the link and priority stores at the current heads, then executed, applying
// the operation; a release into a non-empty free list adds an append step for
// the second write to the single-port link store. A new request is taken
// while the previous result still waits on the output register.
module job_block_pool_manager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] operation
   input  logic [jbpm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // [3:0] block_index, [4] block_present, [12:5] priority_req, [15:13] zero
   input  logic [jbpm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] result_present, [4:1] result_index, [5] free_empty, [6] run_empty,
   // [7] zero
   output logic [jbpm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import jbpm_pkg::*;

   jbpm_cmd_type    cmd;
   jbpm_status_type status;

   logic                     result_present;
   logic [BLOCK_INDEX_W-1:0] result_index;
   logic                     free_empty;
   logic                     run_empty;

   jbpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jbpm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_tuser[OP_W-1:0]),
      .req_block_index    (req_tdata[3:0]),
      .req_block_present  (req_tdata[4]),
      .req_priority_req   (req_tdata[12:5]),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_result_present (result_present),
      .rsp_result_index   (result_index),
      .rsp_free_empty     (free_empty),
      .rsp_run_empty      (run_empty)
   );

   assign rsp_tdata = {1'b0, run_empty, free_empty, result_index, result_present};

endmodule

// ----- src/jbpm_checker.sv -----
// Port-level checks for the job block pool manager, bound to the top level.
module jbpm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [jbpm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import jbpm_pkg::*;

   // A stalled result beat must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // A taken request drops req_tready before any further request is taken.
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // A fresh result appears only after its request was taken, captured and executed.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result beat without a matching request");

   // With no block returned, the index field reads zero.
   a_rsp_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[4:1] == '0)
      else $error("nonzero index on an empty result");

endmodule

bind job_block_pool_manager jbpm_checker u_jbpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
